FILE: hw/rtl/tnp_pkg.sv
// Shared types, character codes and the tone table of the tune text note parser.
package tnp_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned NUM_W  = 16;
  localparam int unsigned DUR_W  = 24;
  localparam int unsigned FREQ_W = 11;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned DVD_W  = 34;
  localparam int unsigned DVS_W  = 32;
  localparam int unsigned PROD_W = DUR_W + NUM_W;

  localparam logic [ROW_W-1:0]  REST_ROW  = 5'd28;
  localparam logic [IDX_W-1:0]  REST_IDX  = 6'd28;
  localparam logic [IDX_W-1:0]  OCT_STEP  = 6'd7;
  localparam logic [NUM_W-1:0]  NUM_MAX   = '1;
  localparam logic [DUR_W-1:0]  DUR_MAX   = '1;
  localparam logic [FREQ_W-1:0] FREQ_MAX  = 11'd1976;
  localparam logic [17:0]       MS_TICKS  = 18'd240000;
  localparam logic [NUM_W-1:0]  BPM_RESET = 16'd120;
  localparam logic [NUM_W-1:0]  DEN_SHORT = 16'd16;
  localparam logic [NUM_W-1:0]  DEN_EIGHT = 16'd8;
  localparam logic [NUM_W-1:0]  DIV_DFLT  = 16'd2;

  localparam logic [CODE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CODE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CODE_W-1:0] CH_APOS  = 8'h27;
  localparam logic [CODE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CODE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CODE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CODE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CODE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CODE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CODE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CODE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CODE_W-1:0] CH_UA    = 8'h41;
  localparam logic [CODE_W-1:0] CH_UB    = 8'h42;
  localparam logic [CODE_W-1:0] CH_UC    = 8'h43;
  localparam logic [CODE_W-1:0] CH_UG    = 8'h47;
  localparam logic [CODE_W-1:0] CH_UH    = 8'h48;
  localparam logic [CODE_W-1:0] CH_UJ    = 8'h4A;
  localparam logic [CODE_W-1:0] CH_UK    = 8'h4B;
  localparam logic [CODE_W-1:0] CH_UL    = 8'h4C;
  localparam logic [CODE_W-1:0] CH_UM    = 8'h4D;
  localparam logic [CODE_W-1:0] CH_UN    = 8'h4E;
  localparam logic [CODE_W-1:0] CH_UP    = 8'h50;
  localparam logic [CODE_W-1:0] CH_UQ    = 8'h51;
  localparam logic [CODE_W-1:0] CH_UR    = 8'h52;
  localparam logic [CODE_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CODE_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [CODE_W-1:0] CH_RBR   = 8'h5D;
  localparam logic [CODE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CODE_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CODE_W-1:0] CH_LA    = 8'h61;
  localparam logic [CODE_W-1:0] CH_LB    = 8'h62;
  localparam logic [CODE_W-1:0] CH_LC    = 8'h63;
  localparam logic [CODE_W-1:0] CH_LG    = 8'h67;
  localparam logic [CODE_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CODE_W-1:0] CH_BAR   = 8'h7C;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_METER  = 2'd1,
    KIND_LENGTH = 2'd2,
    KIND_TEMPO  = 2'd3
  } hdr_kind_t;

  typedef enum logic [19:0] {
    M_IDLE    = 20'h00001,
    M_QUOTE   = 20'h00002,
    M_PLUS    = 20'h00004,
    M_LINE    = 20'h00008,
    M_KEYLINE = 20'h00010,
    M_HLEAD   = 20'h00020,
    M_HNUM    = 20'h00040,
    M_HDEN    = 20'h00080,
    M_QEQ     = 20'h00100,
    M_QBLEAD  = 20'h00200,
    M_QBPM    = 20'h00400,
    M_SHARP   = 20'h00800,
    M_FLAT    = 20'h01000,
    M_OCT     = 20'h02000,
    M_OCTC    = 20'h04000,
    M_MULT    = 20'h08000,
    M_DIV     = 20'h10000,
    M_DOTS    = 20'h20000,
    M_CHORD   = 20'h40000,
    M_AFTER   = 20'h80000
  } mode_t;

  // One classified request as it waits in the queue; an end of text carries code zero.
  typedef struct packed {
    logic              eot;
    logic [CODE_W-1:0] code;
    logic              digit;
    logic              row_ok;
    logic [ROW_W-1:0]  row;
  } tnp_item_t;

  function automatic logic [ROW_W:0] letter_row(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = '0;
    if (c == CH_LZ) r = {3'd0, REST_ROW};
    else if (c >= CH_UC && c <= CH_UG) r = c - CH_UC + 8'd7;
    else if (c == CH_UA || c == CH_UB) r = c - CH_UA + 8'd12;
    else if (c >= CH_LC && c <= CH_LG) r = c - CH_LC + 8'd14;
    else if (c == CH_LA || c == CH_LB) r = c - CH_LA + 8'd19;
    else return '0;
    return {1'b1, r[ROW_W-1:0]};
  endfunction

  function automatic logic skip_header(input logic [CODE_W-1:0] c);
    return (c >= CH_UH && c <= CH_UJ) || (c >= CH_UN && c <= CH_UP) ||
           (c >= CH_UR && c <= CH_UZ) || c == CH_PCT;
  endfunction

  function automatic logic [FREQ_W-1:0] tone_of(input logic [ROW_W-1:0] row,
                                                input logic sharp);
    logic [FREQ_W-1:0] n;
    logic [FREQ_W-1:0] s;
    unique case (row)
      5'd0:  begin n = 11'd131;  s = 11'd139;  end
      5'd1:  begin n = 11'd147;  s = 11'd156;  end
      5'd2:  begin n = 11'd165;  s = 11'd165;  end
      5'd3:  begin n = 11'd175;  s = 11'd185;  end
      5'd4:  begin n = 11'd196;  s = 11'd208;  end
      5'd5:  begin n = 11'd220;  s = 11'd233;  end
      5'd6:  begin n = 11'd247;  s = 11'd247;  end
      5'd7:  begin n = 11'd262;  s = 11'd277;  end
      5'd8:  begin n = 11'd294;  s = 11'd311;  end
      5'd9:  begin n = 11'd330;  s = 11'd330;  end
      5'd10: begin n = 11'd349;  s = 11'd370;  end
      5'd11: begin n = 11'd392;  s = 11'd415;  end
      5'd12: begin n = 11'd440;  s = 11'd466;  end
      5'd13: begin n = 11'd494;  s = 11'd494;  end
      5'd14: begin n = 11'd523;  s = 11'd554;  end
      5'd15: begin n = 11'd587;  s = 11'd622;  end
      5'd16: begin n = 11'd659;  s = 11'd659;  end
      5'd17: begin n = 11'd698;  s = 11'd740;  end
      5'd18: begin n = 11'd784;  s = 11'd831;  end
      5'd19: begin n = 11'd880;  s = 11'd932;  end
      5'd20: begin n = 11'd988;  s = 11'd988;  end
      5'd21: begin n = 11'd1047; s = 11'd1109; end
      5'd22: begin n = 11'd1175; s = 11'd1245; end
      5'd23: begin n = 11'd1319; s = 11'd1319; end
      5'd24: begin n = 11'd1397; s = 11'd1480; end
      5'd25: begin n = 11'd1568; s = 11'd1661; end
      5'd26: begin n = 11'd1760; s = 11'd1865; end
      5'd27: begin n = 11'd1976; s = 11'd1976; end
      default: begin n = '0; s = '0; end
    endcase
    return sharp ? s : n;
  endfunction

  // A flat takes the sharp of the row below; rests and notes raised past the top row sound nothing.
  function automatic logic [FREQ_W-1:0] note_freq(input logic [IDX_W-1:0] idx,
                                                  input logic [1:0] flags);
    logic [IDX_W-1:0] below;
    below = (idx == '0) ? '0 : idx - 6'd1;
    if (idx >= REST_IDX) return '0;
    if (flags[1]) return tone_of(below[ROW_W-1:0], 1'b1);
    return tone_of(idx[ROW_W-1:0], flags[0]);
  endfunction

endpackage

FILE: hw/rtl/tune_text_note_parser.sv
// Top level of the tune text note parser: input queue, parse sequencer and result register.
// A plain character takes one pass through the parse state machine, or more when a state hands it on.
// Ending a header runs a step, the product states S_RMUL and S_RSTART, and then a divider wait.
// A note with a divisor waits on the same divider; a multiplier adds the S_MUL state.
// A finished note enters the result register once its ending character is examined and that register is free.
// Synchronous active-low reset empties the queue, drops any result and restores the defaults.
module tune_text_note_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tnp_pkg::CODE_W-1:0]  in_char_code,
  input  logic                        in_end_of_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tnp_pkg::FREQ_W-1:0]  out_frequency_hz,
  output logic [tnp_pkg::DUR_W-1:0]   out_duration_ms
);
  import tnp_pkg::*;

  tnp_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  tnp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  tnp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (q_item),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frequency_hz (out_frequency_hz),
    .out_duration_ms  (out_duration_ms)
  );

  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frequency_hz <= FREQ_MAX)
    else $error("frequency above the top table entry");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("sequencer popped an empty queue");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> in_ready)
    else $error("empty queue refused a request");

endmodule

FILE: hw/rtl/tnp_front.sv
// Input side: accepts characters, classifies them and queues them for the sequencer.
module tnp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tnp_pkg::CODE_W-1:0]  in_char_code,
  input  logic                        in_end_of_text,
  output tnp_pkg::tnp_item_t          q_item,
  output logic                        q_valid,
  input  logic                        q_pop
);
  import tnp_pkg::*;

  tnp_item_t        slot_r [2];
  tnp_item_t        item_in;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic [ROW_W:0]   lr;
  logic [CODE_W-1:0] code;

  assign code = in_end_of_text ? '0 : in_char_code;
  assign lr   = letter_row(code);

  always_comb begin
    item_in.eot    = in_end_of_text;
    item_in.code   = code;
    item_in.digit  = (code >= CH_ZERO) && (code <= CH_NINE);
    item_in.row_ok = lr[ROW_W];
    item_in.row    = lr[ROW_W-1:0];
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= item_in;
  end

endmodule

FILE: hw/rtl/tnp_div.sv
// Restoring divider, one quotient bit per cycle.
module tnp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tnp_pkg::DVD_W-1:0]  dividend,
  input  logic [tnp_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [tnp_pkg::DVD_W-1:0]  quotient
);
  import tnp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/tnp_back.sv
// Parse sequencer: walks each queued character through the note and header state machine.
module tnp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tnp_pkg::tnp_item_t          q_item,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tnp_pkg::FREQ_W-1:0]  out_frequency_hz,
  output logic [tnp_pkg::DUR_W-1:0]   out_duration_ms
);
  import tnp_pkg::*;

  typedef enum logic [4:0] {
    S_STEP   = 5'b00001,
    S_MUL    = 5'b00010,
    S_RMUL   = 5'b00100,
    S_RSTART = 5'b01000,
    S_DIV    = 5'b10000
  } seq_t;

  seq_t              seq_r, seq_nxt;
  mode_t             mode_r, mode_nxt;
  hdr_kind_t         kind_r, kind_nxt;
  logic              chord_r, chord_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [NUM_W-1:0]  frac_r, frac_nxt;
  logic [NUM_W-1:0]  len_num_r, len_num_nxt;
  logic [NUM_W-1:0]  len_den_r, len_den_nxt;
  logic [NUM_W-1:0]  bpm_r, bpm_nxt;
  logic [DUR_W-1:0]  dflt_r, dflt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        flags_r, flags_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              div_note_r, div_note_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [DVD_W-1:0]  nprod_r;
  logic [DVS_W-1:0]  dprod_r;
  logic              out_valid_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic [DUR_W-1:0]  out_dur_r;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;

  logic              out_free;
  logic              emit_go;

  tnp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    logic [CODE_W-1:0] c;
    logic [19:0]       acc10;
    logic [NUM_W-1:0]  acc_dig;
    logic [DUR_W:0]    dot_sum;
    logic [DUR_W-1:0]  dot_dur;
    logic [17:0]       four_num;
    logic [17:0]       three_den;
    logic              short_len;
    logic              again;
    logic              emit;
    logic              op_mul;
    logic              op_ndiv;
    logic              op_rec;

    c         = q_item.code;
    acc10     = {4'd0, acc_r} * 20'd10 + {16'd0, c[3:0]};
    acc_dig   = (acc10 > {4'd0, NUM_MAX}) ? NUM_MAX : acc10[NUM_W-1:0];
    dot_sum   = {1'b0, dur_r} + {2'b0, dur_r[DUR_W-1:1]};
    dot_dur   = dot_sum[DUR_W] ? DUR_MAX : dot_sum[DUR_W-1:0];
    four_num  = {frac_r, 2'b00};
    three_den = {2'b00, acc_r} + {1'b0, acc_r, 1'b0};
    short_len = (acc_r == '0) || (four_num < three_den);

    again   = 1'b0;
    emit    = 1'b0;
    op_mul  = 1'b0;
    op_ndiv = 1'b0;
    op_rec  = 1'b0;

    mode_nxt     = mode_r;
    kind_nxt     = kind_r;
    chord_nxt    = chord_r;
    acc_nxt      = acc_r;
    frac_nxt     = frac_r;
    len_num_nxt  = len_num_r;
    len_den_nxt  = len_den_r;
    bpm_nxt      = bpm_r;
    dflt_nxt     = dflt_r;
    idx_nxt      = idx_r;
    flags_nxt    = flags_r;
    dur_nxt      = dur_r;
    div_note_nxt = div_note_r;
    seq_nxt      = seq_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dvd      = {{(DVD_W-DUR_W){1'b0}}, dur_r};
    div_dvs      = {{(DVS_W-NUM_W){1'b0}}, (acc_r == '0) ? DIV_DFLT : acc_r};
    emit_go      = 1'b0;

    unique case (mode_r)
      M_QUOTE: if (c == CH_QUOTE) mode_nxt = M_IDLE;
      M_PLUS:  if (c == CH_PLUS) mode_nxt = M_IDLE;
      M_LINE:  if (c == CH_NL) mode_nxt = M_IDLE;
      M_KEYLINE: begin
        if (c == CH_NL) mode_nxt = M_IDLE;
        else if (c == CH_RBR) begin
          chord_nxt = 1'b0;
          mode_nxt  = M_IDLE;
        end
      end
      M_CHORD: begin
        if (c == CH_RBR) begin
          chord_nxt = 1'b0;
          mode_nxt  = M_IDLE;
        end
      end
      M_HLEAD: begin
        if (c != CH_COLON && c != CH_SPACE) begin
          acc_nxt  = '0;
          mode_nxt = M_HNUM;
          again    = 1'b1;
        end
      end
      M_HNUM: begin
        if (q_item.digit) acc_nxt = acc_dig;
        else if (c == CH_SLASH) begin
          frac_nxt = acc_r;
          acc_nxt  = '0;
          mode_nxt = M_HDEN;
        end else begin
          if (kind_r == KIND_TEMPO) bpm_nxt = acc_r;
          else if (kind_r == KIND_METER) begin
            len_num_nxt = 16'd1;
            len_den_nxt = (acc_r == '0) ? DEN_SHORT : DEN_EIGHT;
          end else begin
            len_num_nxt = acc_r;
            len_den_nxt = 16'd1;
          end
          op_rec   = 1'b1;
          mode_nxt = M_IDLE;
          again    = 1'b1;
        end
      end
      M_HDEN: begin
        if (q_item.digit) acc_nxt = acc_dig;
        else if (kind_r == KIND_TEMPO) begin
          mode_nxt = M_QEQ;
          again    = 1'b1;
        end else begin
          if (kind_r == KIND_METER) begin
            len_num_nxt = 16'd1;
            len_den_nxt = short_len ? DEN_SHORT : DEN_EIGHT;
          end else begin
            len_num_nxt = frac_r;
            len_den_nxt = acc_r;
          end
          op_rec   = 1'b1;
          mode_nxt = M_IDLE;
          again    = 1'b1;
        end
      end
      M_QEQ: if (c == CH_EQ) mode_nxt = M_QBLEAD;
      M_QBLEAD: begin
        if (c != CH_SPACE) begin
          acc_nxt  = '0;
          mode_nxt = M_QBPM;
          again    = 1'b1;
        end
      end
      M_QBPM: begin
        if (q_item.digit) acc_nxt = acc_dig;
        else begin
          bpm_nxt  = acc_r;
          op_rec   = 1'b1;
          mode_nxt = M_IDLE;
          again    = 1'b1;
        end
      end
      M_SHARP, M_FLAT: begin
        if (c == CH_CARET && mode_r == M_SHARP) mode_nxt = mode_r;
        else if (c == CH_UNDER) begin
          flags_nxt = flags_r | 2'b10;
          mode_nxt  = M_FLAT;
        end else if (q_item.row_ok) begin
          idx_nxt  = {1'b0, q_item.row};
          dur_nxt  = dflt_r;
          mode_nxt = M_OCT;
        end else begin
          flags_nxt = 2'b00;
          mode_nxt  = M_IDLE;
        end
      end
      M_OCT: begin
        if (c == CH_APOS) begin
          if (idx_r < REST_IDX) idx_nxt = idx_r + OCT_STEP;
        end else again = 1'b1;
        mode_nxt = M_OCTC;
      end
      M_OCTC: begin
        acc_nxt  = '0;
        mode_nxt = M_MULT;
        if (c == CH_COMMA) begin
          if (idx_r < REST_IDX && idx_r >= OCT_STEP) idx_nxt = idx_r - OCT_STEP;
        end else again = 1'b1;
      end
      M_MULT: begin
        if (q_item.digit) acc_nxt = acc_dig;
        else begin
          op_mul   = (acc_r != '0);
          mode_nxt = M_AFTER;
          again    = 1'b1;
        end
      end
      M_DIV: begin
        if (q_item.digit) acc_nxt = acc_dig;
        else begin
          op_ndiv  = 1'b1;
          mode_nxt = M_AFTER;
          again    = 1'b1;
        end
      end
      M_AFTER: begin
        if (c == CH_SLASH) begin
          acc_nxt  = '0;
          mode_nxt = M_DIV;
        end else if (c == CH_GT) begin
          dur_nxt  = dot_dur;
          mode_nxt = M_DOTS;
        end else begin
          emit     = 1'b1;
          mode_nxt = chord_r ? M_CHORD : M_IDLE;
          again    = 1'b1;
        end
      end
      M_DOTS: begin
        if (c == CH_GT) dur_nxt = dot_dur;
        else begin
          emit     = 1'b1;
          mode_nxt = chord_r ? M_CHORD : M_IDLE;
          again    = 1'b1;
        end
      end
      M_IDLE: begin
        if (c == CH_QUOTE) mode_nxt = M_QUOTE;
        else if (c == CH_PLUS) mode_nxt = M_PLUS;
        else if (skip_header(c)) mode_nxt = M_LINE;
        else if (c == CH_UK) mode_nxt = M_KEYLINE;
        else if (c == CH_UM || c == CH_UL || c == CH_UQ) begin
          kind_nxt = (c == CH_UM) ? KIND_METER : ((c == CH_UL) ? KIND_LENGTH : KIND_TEMPO);
          mode_nxt = M_HLEAD;
        end else if (c == CH_LBR) chord_nxt = 1'b1;
        else if (c == CH_BAR || c == CH_RBR) chord_nxt = 1'b0;
        else if (c == CH_CARET) begin
          flags_nxt = 2'b01;
          mode_nxt  = M_SHARP;
        end else if (c == CH_UNDER) begin
          flags_nxt = 2'b10;
          mode_nxt  = M_FLAT;
        end else if (q_item.row_ok) begin
          flags_nxt = 2'b00;
          idx_nxt   = {1'b0, q_item.row};
          dur_nxt   = dflt_r;
          mode_nxt  = M_OCT;
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    // The parse state holds while the sequencer waits on arithmetic, on an empty queue
    // or on a note that waits for the result register to drain.
    if (seq_r != S_STEP || !q_valid || (emit && !out_free)) begin
      mode_nxt    = mode_r;
      kind_nxt    = kind_r;
      chord_nxt   = chord_r;
      acc_nxt     = acc_r;
      frac_nxt    = frac_r;
      len_num_nxt = len_num_r;
      len_den_nxt = len_den_r;
      bpm_nxt     = bpm_r;
      idx_nxt     = idx_r;
      flags_nxt   = flags_r;
      dur_nxt     = dur_r;
    end

    unique case (seq_r)
      S_STEP: begin
        if (q_valid && !(emit && !out_free)) begin
          emit_go = emit;
          if (op_mul) seq_nxt = S_MUL;
          else if (op_ndiv) begin
            div_start    = 1'b1;
            div_note_nxt = 1'b1;
            seq_nxt      = S_DIV;
          end else if (op_rec) seq_nxt = S_RMUL;
          else if (!again) begin
            q_pop = 1'b1;
            if (q_item.eot) mode_nxt = M_IDLE;
          end
        end
      end
      S_MUL: begin
        dur_nxt = (prod_r[PROD_W-1:DUR_W] != '0) ? DUR_MAX : prod_r[DUR_W-1:0];
        seq_nxt = S_STEP;
      end
      S_RMUL: seq_nxt = S_RSTART;
      S_RSTART: begin
        if (dprod_r == '0) begin
          dflt_nxt = '0;
          seq_nxt  = S_STEP;
        end else begin
          div_start    = 1'b1;
          div_dvd      = nprod_r;
          div_dvs      = dprod_r;
          div_note_nxt = 1'b0;
          seq_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_note_r) dur_nxt = div_q[DUR_W-1:0];
          else dflt_nxt = (div_q[DVD_W-1:DUR_W] != '0) ? DUR_MAX : div_q[DUR_W-1:0];
          seq_nxt = S_STEP;
        end
      end
      default: seq_nxt = S_STEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_STEP;
      mode_r      <= M_IDLE;
      kind_r      <= KIND_NONE;
      chord_r     <= 1'b0;
      acc_r       <= '0;
      frac_r      <= '0;
      len_num_r   <= 16'd1;
      len_den_r   <= DEN_EIGHT;
      bpm_r       <= BPM_RESET;
      dflt_r      <= '0;
      idx_r       <= '0;
      flags_r     <= '0;
      dur_r       <= '0;
      div_note_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      mode_r     <= mode_nxt;
      kind_r     <= kind_nxt;
      chord_r    <= chord_nxt;
      acc_r      <= acc_nxt;
      frac_r     <= frac_nxt;
      len_num_r  <= len_num_nxt;
      len_den_r  <= len_den_nxt;
      bpm_r      <= bpm_nxt;
      dflt_r     <= dflt_nxt;
      idx_r      <= idx_nxt;
      flags_r    <= flags_nxt;
      dur_r      <= dur_nxt;
      div_note_r <= div_note_nxt;
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Products are registered every cycle; the sequencer reads them in the cycle after their inputs settle.
  always_ff @(posedge clk) begin
    prod_r  <= dur_r * acc_r;
    nprod_r <= {{(DVD_W-18){1'b0}}, MS_TICKS} * {{(DVD_W-NUM_W){1'b0}}, len_num_r};
    dprod_r <= {{(DVS_W-NUM_W){1'b0}}, len_den_r} * {{(DVS_W-NUM_W){1'b0}}, bpm_r};
    if (emit_go) begin
      out_freq_r <= note_freq(idx_r, flags_r);
      out_dur_r  <= dur_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frequency_hz = out_freq_r;
  assign out_duration_ms  = out_dur_r;

endmodule

FILE: tb/sv/tune_text_note_parser_tb.sv
// Self-checking testbench of the tune text note parser: directed tunes, then random ones.
module tune_text_note_parser_tb;
  import tnp_pkg::*;

  localparam int unsigned PMAX = 65535;
  localparam int unsigned DMAX = 24'hFFFFFF;

  // Parser phases of the predictor.
  typedef enum int {
    P_IDLE, P_QUOTE, P_PLUS, P_LINE, P_KEYLINE, P_HLEAD, P_HNUM, P_HDEN, P_QEQ,
    P_QBLEAD, P_QBPM, P_SHARP, P_FLAT, P_OCT, P_OCTC, P_MULT, P_DIV, P_DOTS, P_CHORD
  } phase_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } tone_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CODE_W-1:0] in_char_code;
  logic              in_end_of_text;
  logic              out_valid;
  logic              out_ready;
  logic [FREQ_W-1:0] out_frequency_hz;
  logic [DUR_W-1:0]  out_duration_ms;

  tune_text_note_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_code(in_char_code), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frequency_hz(out_frequency_hz), .out_duration_ms(out_duration_ms)
  );

  tone_t  tones_due[$];
  int     error_count;
  int     tones_seen;

  // Predictor state.
  phase_t      ph;
  bit          chord;
  hdr_kind_t   kind;
  int unsigned acc, frac, len_num, len_den, bpm, dflt, idx, flags, dur;

  initial clk = 1'b0;

  always #4 clk = ~clk;

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int unsigned row_of(input int c);
    if (c == CH_LZ) return 28;
    if (c >= CH_UC && c <= CH_UG) return c - CH_UC + 7;
    if (c == CH_UA || c == CH_UB) return c - CH_UA + 12;
    if (c >= CH_LC && c <= CH_LG) return c - CH_LC + 14;
    if (c == CH_LA || c == CH_LB) return c - CH_LA + 19;
    return 99;
  endfunction

  function automatic int unsigned tone_hz(input int unsigned r, input bit sh);
    int unsigned nat[28] = '{131, 147, 165, 175, 196, 220, 247, 262, 294, 330, 349, 392,
      440, 494, 523, 587, 659, 698, 784, 880, 988, 1047, 1175, 1319, 1397, 1568, 1760, 1976};
    int unsigned shp[28] = '{139, 156, 165, 185, 208, 233, 247, 277, 311, 330, 370, 415,
      466, 494, 554, 622, 659, 740, 831, 932, 988, 1109, 1245, 1319, 1480, 1661, 1865, 1976};
    return sh ? shp[r] : nat[r];
  endfunction

  function automatic int unsigned clip_dur(input longint unsigned v);
    return (v > DMAX) ? DMAX : int'(v);
  endfunction

  task automatic push_digit(input int c);
    longint unsigned v;
    v = longint'(acc) * 10 + (c - CH_ZERO);
    acc = (v > PMAX) ? PMAX : int'(v);
  endtask

  task automatic refresh_default();
    longint unsigned dv;
    dv = longint'(len_den) * bpm;
    dflt = (dv == 0) ? 0 : clip_dur(64'd240000 * len_num / dv);
  endtask

  task automatic set_fraction(input int unsigned num, input int unsigned den, input bit has_den);
    bit shortn;
    if (kind == KIND_METER) begin
      shortn = has_den ? (den == 0 || 4 * longint'(num) < 3 * longint'(den)) : (num == 0);
      len_num = 1;
      len_den = shortn ? 16 : 8;
    end else begin
      len_num = num;
      len_den = has_den ? den : 1;
    end
    refresh_default();
  endtask

  task automatic emit_tone();
    tone_t t;
    int unsigned f;
    if (idx >= 28) f = 0;
    else if (flags[1]) f = tone_hz((idx == 0) ? 0 : idx - 1, 1'b1);
    else f = tone_hz(idx, flags[0]);
    t.freq = FREQ_W'(f);
    t.dur = DUR_W'(dur);
    tones_due.push_back(t);
    ph = chord ? P_CHORD : P_IDLE;
  endtask

  task automatic add_dot();
    dur = clip_dur(longint'(dur) + dur / 2);
  endtask

  // Common tail of multiplier and divisor; returns 1 when the note ended.
  task automatic close_number(input int c, output bit ended);
    ended = 1'b0;
    if (c == CH_SLASH) begin
      acc = 0;
      ph = P_DIV;
    end else if (c == CH_GT) begin
      add_dot();
      ph = P_DOTS;
    end else begin
      emit_tone();
      ended = 1'b1;
    end
  endtask

  task automatic reset_model();
    ph = P_IDLE; chord = 0; kind = KIND_NONE; acc = 0; frac = 0;
    len_num = 1; len_den = 8; bpm = 120; dflt = 0; idx = 0; flags = 0; dur = 0;
  endtask

  task automatic model_char(input bit eot, input int code);
    int c;
    bit again;
    bit ended;
    int unsigned r;
    c = eot ? 256 : code;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      r = row_of(c);
      case (ph)
        P_QUOTE: if (c == CH_QUOTE) ph = P_IDLE;
        P_PLUS: if (c == CH_PLUS) ph = P_IDLE;
        P_LINE: if (c == CH_NL) ph = P_IDLE;
        P_KEYLINE: begin
          if (c == CH_NL) ph = P_IDLE;
          else if (c == CH_RBR) begin chord = 0; ph = P_IDLE; end
        end
        P_CHORD: if (c == CH_RBR) begin chord = 0; ph = P_IDLE; end
        P_HLEAD: if (c != CH_COLON && c != CH_SPACE) begin
          acc = 0; ph = P_HNUM; again = 1;
        end
        P_HNUM: begin
          if (c >= CH_ZERO && c <= CH_NINE) push_digit(c);
          else if (c == CH_SLASH) begin frac = acc; acc = 0; ph = P_HDEN; end
          else begin
            if (kind == KIND_TEMPO) begin bpm = acc; refresh_default(); end
            else set_fraction(acc, 0, 0);
            ph = P_IDLE; again = 1;
          end
        end
        P_HDEN: begin
          if (c >= CH_ZERO && c <= CH_NINE) push_digit(c);
          else if (kind == KIND_TEMPO) begin ph = P_QEQ; again = 1; end
          else begin set_fraction(frac, acc, 1); ph = P_IDLE; again = 1; end
        end
        P_QEQ: if (c == CH_EQ) ph = P_QBLEAD;
        P_QBLEAD: if (c != CH_SPACE) begin acc = 0; ph = P_QBPM; again = 1; end
        P_QBPM: begin
          if (c >= CH_ZERO && c <= CH_NINE) push_digit(c);
          else begin bpm = acc; refresh_default(); ph = P_IDLE; again = 1; end
        end
        P_SHARP, P_FLAT: begin
          if (c == CH_CARET && ph == P_SHARP) ;
          else if (c == CH_UNDER) begin flags |= 2; ph = P_FLAT; end
          else if (r != 99) begin idx = r; dur = dflt; ph = P_OCT; end
          else begin flags = 0; ph = P_IDLE; end
        end
        P_OCT: begin
          if (c == CH_APOS) begin
            if (idx < 28) idx += 7;
          end else again = 1;
          ph = P_OCTC;
        end
        P_OCTC: begin
          acc = 0;
          ph = P_MULT;
          if (c == CH_COMMA) begin
            if (idx < 28 && idx >= 7) idx -= 7;
          end else again = 1;
        end
        P_MULT: begin
          if (c >= CH_ZERO && c <= CH_NINE) push_digit(c);
          else begin
            if (acc > 0) dur = clip_dur(longint'(dur) * acc);
            close_number(c, ended);
            again = ended;
          end
        end
        P_DIV: begin
          if (c >= CH_ZERO && c <= CH_NINE) push_digit(c);
          else begin
            dur = dur / ((acc != 0) ? acc : 2);
            close_number(c, ended);
            again = ended;
          end
        end
        P_DOTS: begin
          if (c == CH_GT) add_dot();
          else begin emit_tone(); again = 1; end
        end
        default: begin
          ph = P_IDLE;
          if (c == CH_QUOTE) ph = P_QUOTE;
          else if (c == CH_PLUS) ph = P_PLUS;
          else if ((c >= CH_UH && c <= CH_UJ) || (c >= CH_UN && c <= CH_UP) ||
                   (c >= CH_UR && c <= CH_UZ) || c == CH_PCT) ph = P_LINE;
          else if (c == CH_UK) ph = P_KEYLINE;
          else if (c == CH_UM || c == CH_UL || c == CH_UQ) begin
            kind = (c == CH_UM) ? KIND_METER : ((c == CH_UL) ? KIND_LENGTH : KIND_TEMPO);
            ph = P_HLEAD;
          end
          else if (c == CH_LBR) chord = 1;
          else if (c == CH_BAR || c == CH_RBR) chord = 0;
          else if (c == CH_CARET) begin flags = 1; ph = P_SHARP; end
          else if (c == CH_UNDER) begin flags = 2; ph = P_FLAT; end
          else if (r != 99) begin flags = 0; idx = r; dur = dflt; ph = P_OCT; end
        end
      endcase
    end
    if (eot) ph = P_IDLE;
  endtask

  // Random gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays high into the next request when no gap follows.
  task automatic send_request(input bit eot, input int code);
    int g;
    in_valid <= 1'b1;
    in_char_code <= code[7:0];
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_char(eot, code);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_request(1'b0, s[i]);
  endtask

  always @(posedge clk) begin
    tone_t want;
    if (rst_n && out_valid && out_ready) begin
      tones_seen++;
      if (tones_due.size() == 0) report("unexpected tone", out_frequency_hz, 0);
      else begin
        want = tones_due.pop_front();
        if (out_frequency_hz !== want.freq) report("frequency", out_frequency_hz, want.freq);
        if (out_duration_ms !== want.dur) report("duration", out_duration_ms, want.dur);
      end
    end
  end

  // Consumer stalls, with calm stretches.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if ((tones_seen / 40) % 3 == 2) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) < 70);
  end

  task automatic test_headers();
    send_text("L:1/4\nC D2 E/ F/4 G3/2 A> B>> c' d, e'2> z,3 _z ^z'/ |\n");
    send_text("M:3/4\nC M:2/4\nD M:5\nE M:0/0\nF M:C\nG L:1\nA L:0/0\nB ");
    send_text("Q:1/4=90\nc Q: 200\nd Q:0\ne Q:70000\nf L:65535/1\ng2 ");
    send_text("Q:120\nL:1/8\n");
  endtask

  task automatic test_accidentals();
    send_text("^C _D ^^E __F ^_G _^A ^B _C, ^c' _b' ^x a ^_ ^z _z ");
    send_request(1'b1, 0);
  endtask

  task automatic test_skipping();
    send_text("\"Am7 text\"C +trill+D T:title\nE K:G]F %comment\nG [CEG]A [c|B ");
    send_text("X:1\n[K:D]e c0 d00/0 e9999999 f>>>>>>>>>>>>>>>>>>>>>>>>>>>");
    send_request(1'b1, 0);
    send_text("Q:1/4");
    send_request(1'b1, 0);
    send_text("L:1/8\nQ:120\n");
    send_request(1'b1, 0);
  endtask

  function automatic int pick_char();
    string notes = "CDEFGABcdefgabz";
    string mods = "',0123456789/>^_";
    string seps = " |[]\n";
    int p;
    p = $urandom_range(99);
    if (p < 35) return notes[$urandom_range(notes.len() - 1)];
    if (p < 70) return mods[$urandom_range(mods.len() - 1)];
    if (p < 80) return seps[$urandom_range(seps.len() - 1)];
    return $urandom_range(255);
  endfunction

  task automatic test_random_tunes();
    string s;
    int sent;
    int p;
    sent = 0;
    while (sent < 720) begin
      p = $urandom_range(99);
      if (p < 6) begin
        s = $sformatf("L:%0d/%0d\n", $urandom_range(1, 4), 1 << $urandom_range(0, 5));
        send_text(s);
        sent += s.len();
      end else if (p < 10) begin
        s = $sformatf("Q:1/4=%0d\n", $urandom_range(40, 300));
        send_text(s);
        sent += s.len();
      end else if (p < 12) begin
        s = $sformatf("M:%0d/%0d\n", $urandom_range(0, 9), $urandom_range(0, 9));
        send_text(s);
        sent += s.len();
      end else if (p < 13) begin
        send_request(1'b1, $urandom_range(255));
        sent++;
      end else begin
        send_request(1'b0, pick_char());
        sent++;
      end
    end
    send_request(1'b1, 0);
  endtask

  initial begin
    int waited;
    error_count = 0;
    tones_seen = 0;
    reset_model();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = '0;
    in_end_of_text = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_headers();
    test_accidentals();
    test_skipping();
    test_random_tunes();
    in_valid <= 1'b0;
    waited = 0;
    while (tones_due.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (error_count == 0 && tones_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
